// File: src/scla_pkg.sv
// Shared types and constants for the serial command line assembler.
// Holds the character codes, the result kinds, the controller states and
// the command and status records between the controller and the datapath.
`default_nettype none

package scla_pkg;

   // Default line store size in bytes.
   localparam int LINE_BYTES_DEF = 32;

   // Width of one character.
   localparam int DATA_W = 8;

   // Control characters recognized by the line editor.
   localparam logic [DATA_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [DATA_W-1:0] CH_CR        = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF        = 8'h0A;
   localparam logic [DATA_W-1:0] CH_NUL       = 8'h00;

   // Configuration register indexes.
   localparam logic CSR_ECHO_ENABLE    = 1'b0;
   localparam logic CSR_COMMAND_ENABLE = 1'b1;

   // Kind of a result.
   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_TERM = 2'd2
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_EMIT,
      S_TERM
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // request accepted this cycle
      logic load_echo;  // load an echo result into the output register
      logic idx_clear;  // restart the read-out index
      logic rd_issue;   // read the line store at the read-out index
      logic load_char;  // load a command character result
      logic load_term;  // load the terminator result and clear the line
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_lineend; // the offered byte ends the line
      logic echo_en;    // echo is enabled
      logic out_free;   // the output register can take a result this cycle
      logic idx_done;   // every stored character has been read out
   } status_type;

endpackage

`default_nettype wire

// File: src/scla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on scla_pkg for its default sizes.
`default_nettype none

module scla_ram
   import scla_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = LINE_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/scla_ctrl.sv
// Controller state machine of the command line assembler.
// Depends on scla_pkg for the state, command and status types.
`default_nettype none

module scla_ctrl
   import scla_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && status.out_free && status.is_lineend) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (status.idx_done) begin
               state_in = S_TERM;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               state_in = S_ISSUE;
            end
         end
         S_TERM: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready    = status.out_free;
            cmd.take      = req_tvalid && status.out_free;
            cmd.load_echo = req_tvalid && status.out_free && status.echo_en;
            cmd.idx_clear = req_tvalid && status.out_free && status.is_lineend;
         end
         S_ISSUE: begin
            cmd.rd_issue = !status.idx_done;
         end
         S_EMIT: begin
            cmd.load_char = status.out_free;
         end
         S_TERM: begin
            cmd.load_term = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Only one result is loaded into the output register per cycle.
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_echo, cmd.load_char, cmd.load_term}))
      else $error("more than one result loaded in a cycle");

   // A line end always leads to the read-out of the line.
   a_lineend_readout: assert property (@(posedge clock) disable iff (reset)
      cmd.idx_clear |=> state_ff == S_ISSUE)
      else $error("line end did not start the read-out");

   // A stalled character keeps the controller waiting to emit it.
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !status.out_free) |=> state_ff == S_EMIT)
      else $error("character dropped while the output was stalled");

endmodule

`default_nettype wire

// File: src/scla_dp.sv
// Datapath of the command line assembler: configuration registers, line
// store, length and overflow state, read-out index and output register.
// Depends on scla_pkg and scla_ram.
`default_nettype none

module scla_dp
   import scla_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic              csr_wdata,
   input  wire logic [DATA_W-1:0] rx_byte,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic              rsp_tready,
   output logic                   rsp_valid,
   output kind_type               rsp_kind,
   output logic      [DATA_W-1:0] rsp_data,
   output logic                   rsp_overflow,
   output logic                   rsp_last
);

   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(LINE_BYTES - 1);

   logic              echo_en_ff;
   logic              cmd_en_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              dropped_ff, dropped_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              wr_en;
   logic              is_bs;
   logic              is_lineend;
   logic [DATA_W-1:0] rd_data;
   logic              out_free;

   logic              out_valid_ff, out_valid_in;
   kind_type          out_kind_ff, out_kind_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_ovf_ff, out_ovf_in;
   logic              out_last_ff, out_last_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_en_ff <= 1'b0;
         cmd_en_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ECHO_ENABLE:    echo_en_ff <= csr_wdata;
            CSR_COMMAND_ENABLE: cmd_en_ff  <= csr_wdata;
            default:            echo_en_ff <= echo_en_ff;
         endcase
      end
   end

   // Classify the offered byte.
   assign is_bs      = (rx_byte == CH_BACKSPACE);
   assign is_lineend = cmd_en_ff && ((rx_byte == CH_CR) || (rx_byte == CH_LF));

   // Line editing: backspace, append or drop, and clearing after the terminator.
   always_comb begin
      len_in     = len_ff;
      dropped_in = dropped_ff;
      wr_en      = 1'b0;
      if (cmd.load_term) begin
         len_in     = '0;
         dropped_in = 1'b0;
      end else if (cmd.take && !is_lineend) begin
         if (is_bs) begin
            if (len_ff != '0) begin
               len_in = len_ff - LEN_W'(1);
            end
         end else if (len_ff < LAST_POS) begin
            wr_en  = 1'b1;
            len_in = len_ff + LEN_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         dropped_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         dropped_ff <= dropped_in;
      end
   end

   // Line store.
   scla_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Read-out index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.load_char) begin
         idx_in = idx_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Output register; it takes a new result when empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      if (cmd.load_echo) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_ECHO;
         out_data_in  = rx_byte;
         out_ovf_in   = 1'b0;
         out_last_in  = !is_lineend;
      end else if (cmd.load_char) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_CHAR;
         out_data_in  = rd_data;
         out_ovf_in   = 1'b0;
         out_last_in  = 1'b0;
      end else if (cmd.load_term) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_TERM;
         out_data_in  = CH_NUL;
         out_ovf_in   = dropped_ff;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_last     = out_last_ff;

   // Status toward the controller.
   always_comb begin
      status.is_lineend = is_lineend;
      status.echo_en    = echo_en_ff;
      status.out_free   = out_free;
      status.idx_done   = (idx_ff == len_ff);
   end

   // The line never holds more than one byte less than the store size.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LAST_POS)
      else $error("line length beyond the store");

   // The terminator clears the line and the overflow flag.
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_term |=> (len_ff == '0) && !dropped_ff)
      else $error("line not cleared after the terminator");

   // The read-out index never passes the line length.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> idx_ff < len_ff)
      else $error("read beyond the stored line");

endmodule

`default_nettype wire

// File: src/serial_command_line_assembler.sv
// Command line assembler: an ordinary byte or backspace is accepted while the
// block is idle and the output is free; its echo, if enabled, shows on the
// result channel the next cycle. A line end reads each stored character out
// with one store read and one output load, then loads the terminator, and
// takes no new request until then; rsp_tready stalls hold up the read-out.
// Synchronous active-high reset clears length, flag, registers, not the store.
`default_nettype none

module serial_command_line_assembler
   import scla_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [7:0] data, [8] overflow, [15:9] zero
   output logic      [1:0]  rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast
);

   cmd_type           cmd;
   status_type        status;
   kind_type          rsp_kind;
   logic [DATA_W-1:0] rsp_data;
   logic              rsp_overflow;

   scla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scla_dp #(
      .LINE_BYTES (LINE_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rx_byte      (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_kind),
      .rsp_data     (rsp_data),
      .rsp_overflow (rsp_overflow),
      .rsp_last     (rsp_tlast)
   );

   // Pack the result fields.
   assign rsp_tdata = {7'b0, rsp_overflow, rsp_data};
   assign rsp_tuser = rsp_kind;

endmodule

`default_nettype wire

// File: tb/sv/serial_command_line_assembler_test.sv
// Self-checking testbench for serial_command_line_assembler: it streams bytes in,
// predicts the echo, command and terminator results in step, and compares every result.
// Depends on scla_pkg and the assembler RTL.
`timescale 1ns / 1ps

module serial_command_line_assembler_test;
   import scla_pkg::*;

   // One result as the block should produce it.
   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       ovf;
      logic       last;
   } line_result_t;

   localparam int STALL_CYCLES = 400;
   localparam int SETTLE_CYCLES = 2 * LINE_BYTES_DEF + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] data, [8] overflow, [15:9] zero
   logic [1:0]  rsp_tuser;            // [1:0] kind
   logic        rsp_tlast;

   // Bytes waiting to be sent and results waiting to arrive.
   logic [7:0]   rx_bytes_q[$];
   line_result_t line_results_q[$];

   // Mirror of the line editor state and its registers.
   logic [7:0] model_line [0:LINE_BYTES_DEF-1];
   int         model_len = 0;
   logic       model_dropped = 1'b0;
   logic       echo_on = 1'b0;
   logic       deliver_on = 1'b1;

   int   error_count = 0;
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   logic hold_done = 1'b0;
   int   stall_left = 0;

   serial_command_line_assembler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted byte to the mirrored line and queues the results it causes.
   function automatic void edit_line(input logic [7:0] rx);
      line_result_t pend [0:LINE_BYTES_DEF];
      int n;
      n = 0;
      if (echo_on) begin
         pend[n] = '{KIND_ECHO, rx, 1'b0, 1'b0};
         n++;
      end
      if (rx == CH_BACKSPACE) begin
         if (model_len > 0) model_len--;
      end else if (deliver_on && (rx == CH_CR || rx == CH_LF)) begin
         for (int k = 0; k < model_len; k++) begin
            pend[n] = '{KIND_CHAR, model_line[k], 1'b0, 1'b0};
            n++;
         end
         pend[n] = '{KIND_TERM, CH_NUL, model_dropped, 1'b0};
         n++;
         model_len = 0;
         model_dropped = 1'b0;
      end else if (model_len < LINE_BYTES_DEF - 1) begin
         model_line[model_len] = rx;
         model_len++;
      end else begin
         model_dropped = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         pend[k].last = (k == n - 1);
         line_results_q.push_back(pend[k]);
      end
   endfunction

   // Request driver: holds a byte until it is taken, then offers the next one or idles.
   always @(posedge clock) begin : driver
      logic give;
      logic [7:0] next_byte;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) edit_line(req_tdata);
         give = (rx_bytes_q.size() != 0) && (calm || $urandom_range(99) >= 18);
         if (give) begin
            next_byte = rx_bytes_q.pop_front();
            req_tdata <= next_byte;
         end
         req_tvalid <= give;
      end
   end

   // Result monitor: checks each accepted result and paces rsp_tready, with one long stall.
   always @(posedge clock) begin : monitor
      line_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (line_results_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result kind %0d data %h", $time, rsp_tuser,
                        rsp_tdata[7:0]);
            end else begin
               want = line_results_q.pop_front();
               if (rsp_tuser != want.kind) begin
                  error_count++;
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_tuser);
               end
               if (rsp_tdata[7:0] != want.data) begin
                  error_count++;
                  $display("%0t: data expected %h actual %h", $time, want.data,
                           rsp_tdata[7:0]);
               end
               if (rsp_tdata[8] != want.ovf) begin
                  error_count++;
                  $display("%0t: overflow expected %b actual %b", $time, want.ovf,
                           rsp_tdata[8]);
               end
               if (rsp_tlast != want.last) begin
                  error_count++;
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_request && !hold_done) begin
            stall_left = STALL_CYCLES;
            hold_done = 1'b1;
         end
         rsp_tready <= (stall_left == 0) && (calm || $urandom_range(99) >= 18);
      end
   end

   // Writes one register; the sender is idle whenever this is called.
   task automatic write_csr(input logic idx, input logic value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ECHO_ENABLE) echo_on = value;
      else deliver_on = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every byte is sent and every result has come, then lets the block go idle.
   task automatic settle();
      do @(negedge clock);
      while (rx_bytes_q.size() != 0 || req_tvalid || line_results_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Queues either one stray byte or a line with random text and backspaces and an end.
   function automatic int queue_random_line();
      int len;
      if ($urandom_range(9) == 0) begin
         rx_bytes_q.push_back(8'($urandom_range(255)));
         return 1;
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(9) == 0) rx_bytes_q.push_back(CH_BACKSPACE);
         else rx_bytes_q.push_back(8'($urandom_range(255)));
      end
      rx_bytes_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
      return len + 1;
   endfunction

   // Register settings for the random phases; the fifth phase carries the long stall.
   localparam logic PHASE_ECHO [0:5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam logic PHASE_DELIVER [0:5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

   initial begin : stimulus
      int count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: backspace at the start, empty line end, zero and all-ones bytes,
      // an edit before the end, then CR and LF stored while delivery is off.
      write_csr(CSR_ECHO_ENABLE, 1'b1);
      write_csr(CSR_COMMAND_ENABLE, 1'b1);
      rx_bytes_q = '{CH_BACKSPACE, CH_CR, CH_NUL, 8'hFF, 8'h41, CH_BACKSPACE, 8'h7E, CH_LF,
                     8'h55, 8'hAA, CH_CR};
      settle();
      write_csr(CSR_COMMAND_ENABLE, 1'b0);
      rx_bytes_q = '{8'h31, CH_CR, CH_LF, CH_BACKSPACE, CH_CR};
      settle();
      write_csr(CSR_COMMAND_ENABLE, 1'b1);
      rx_bytes_q = '{CH_LF};
      settle();

      // Random phases over every register setting.
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_ECHO_ENABLE, PHASE_ECHO[p]);
         write_csr(CSR_COMMAND_ENABLE, PHASE_DELIVER[p]);
         calm <= (p == 0);
         hold_request <= (p == 4);
         count = 0;
         while (count < 22) count += queue_random_line();
         settle();
      end
      calm <= 1'b0;

      if (line_results_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, line_results_q.size());
      end
      if (error_count == 0) begin
         $display("serial_command_line_assembler_test: done, clean");
      end else begin
         $display("serial_command_line_assembler_test: done, errors");
      end
      $finish;
   end

   // Stops a hung run.
   initial begin : watchdog
      #2000000;
      $display("serial_command_line_assembler_test: done, errors");
      $finish;
   end

endmodule
